>>> design/bitmap_pixel_gen_cloud_overlay_assert.svh
// Assertion macros for the bitmap pixel generator.
// Used by bitmap_pixel_gen_cloud_overlay.sv; expects clk and rst_n in scope.
`ifndef BITMAP_PIXEL_GEN_CLOUD_OVERLAY_ASSERT_SVH
`define BITMAP_PIXEL_GEN_CLOUD_OVERLAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BPGCO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPGCO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bpgco_pkg.sv
// Shared types and constants for the bitmap pixel generator.
// No dependencies; imported by bitmap_pixel_gen_cloud_overlay.
`default_nettype none

package bpgco_pkg;

  // Request opcodes
  localparam logic [2:0] OP_VIDEO = 3'd0;
  localparam logic [2:0] OP_COLOR = 3'd1;
  localparam logic [2:0] OP_CMAP  = 3'd2;
  localparam logic [2:0] OP_CLOUD = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // Pens
  localparam logic [2:0] PEN_CLOUD   = 3'd7;
  localparam logic [2:0] PEN_BACK_HI = 3'd6;
  localparam logic [2:0] PEN_BACK_LO = 3'd2;

  // Cloud band height in rows below the cloud position
  localparam logic [7:0] CLOUD_ROWS = 8'd64;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [12:0] address;
    logic [7:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [2:0] pixel_color;
    logic       last;
  } out_pix_t;

endpackage

`default_nettype wire

>>> design/bitmap_pixel_gen_cloud_overlay.sv
// Bitmap pixel generator with colour RAM, colour map and cloud overlay.
// Depends on bpgco_pkg and bitmap_pixel_gen_cloud_overlay_assert.svh.
`default_nettype none

// A video write request turns one bitmap byte into eight pixels, bit 0
// first, one pixel per clock on the out channel while out_stall is low;
// a steady stream of video writes is therefore paced by the pixel
// serializer. Table loads, colour RAM writes and frame ticks produce no
// pixels. Requests are accepted while the previous byte is still being
// shifted out: a read stage (the memory output registers) holds the next
// byte until the serializer frees up. After reset the colour RAM is swept
// to zero, one entry per cycle, across all 1024 entries; in_stall stays
// high until the sweep ends. Writes to flip are taken at any time but are
// meant only while the block is idle.
module bitmap_pixel_gen_cloud_overlay (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  bpgco_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  wire                 out_stall,
  output bpgco_pkg::out_pix_t out_pix,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data
);

  import bpgco_pkg::*;

`include "bitmap_pixel_gen_cloud_overlay_assert.svh"

  // ---------------------------------------------------------------------
  // Memories. All reads are synchronous, into registered outputs.
  // color_store and cmap_ram share the packed index
  // {addr[12:8], addr[4:0]}; the cloud table is split in even and odd
  // halves so both nibbles used by one byte come out of a single read.
  // ---------------------------------------------------------------------
  logic [2:0] color_store [1024];
  logic [3:0] cmap_ram    [1024];
  logic [3:0] cloud_even  [128];
  logic [3:0] cloud_odd   [128];

  // Control state
  logic       flip_r;
  logic       clr_active_r;
  logic [9:0] clr_addr_r;
  logic [7:0] drift_row_r;
  logic [2:0] tick_div_r;

  // Read stage: request fields plus registered memory data
  logic       s1_valid_r;
  logic [7:0] s1_val_r;
  logic [4:0] s1_x0_r;
  logic [7:0] s1_y_r;
  logic       s1_inrange_r;
  logic [2:0] cstore_q_r;
  logic [3:0] cmap_q_r;
  logic [3:0] ceven_q_r;
  logic [3:0] codd_q_r;

  // Serializer
  logic       ser_valid_r;
  logic [2:0] ser_cnt_r;
  logic [7:0] ser_val_r;
  logic [4:0] ser_x0_r;
  logic [7:0] ser_y_r;
  logic [2:0] ser_fore_r;
  logic [2:0] ser_back_r;
  logic [7:0] ser_cloud_r;

  // Output register
  logic     out_valid_r;
  out_pix_t out_pix_r;

  // Handshake and control
  logic       in_acc;
  logic       vid_acc;
  logic       out_adv;
  logic       pix_fire;
  logic       ser_done;
  logic       ser_load;
  logic       s1_hold;
  logic [9:0] pack_idx;
  logic [7:0] y_in;
  logic [7:0] cy;
  logic [6:0] cloud_row;

  // Serializer load values
  logic [7:0] cloud_bits;
  logic       cloud_en;

  // Pixel datapath
  logic [7:0] pix_x;
  logic [2:0] pix_color;

  assign out_adv  = !out_valid_r || !out_stall;
  assign pix_fire = ser_valid_r && out_adv;
  assign ser_done = pix_fire && (ser_cnt_r == 3'd7);
  assign ser_load = s1_valid_r && (!ser_valid_r || ser_done);
  assign s1_hold  = s1_valid_r && !ser_load;
  assign in_stall = clr_active_r || s1_hold;
  assign in_acc   = in_valid && !in_stall;
  assign vid_acc  = in_acc && (in_req.opcode == OP_VIDEO);

  assign pack_idx  = {in_req.address[12:8], in_req.address[4:0]};
  assign y_in      = in_req.address[12:5];
  assign cy        = y_in - drift_row_r;
  // Table index ((~cy & 0x3f) << 2) | ((x >> 2) & 3); x0 is a multiple
  // of 8, so the pair {idx, idx+1} lives in one even/odd row.
  assign cloud_row = {~cy[5:0], in_req.address[0]};

  // ---------------------------------------------------------------------
  // Memory ports. At most one request is handled per cycle and a read always
  // happens on a later edge than any earlier write, so no forwarding.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      color_store[clr_addr_r] <= '0;
    end else if (in_acc && (in_req.opcode == OP_COLOR)) begin
      color_store[pack_idx] <= in_req.value[2:0];
    end
    if (vid_acc) begin
      cstore_q_r <= color_store[pack_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_req.opcode == OP_CMAP)) begin
      cmap_ram[in_req.address[9:0]] <= in_req.value[3:0];
    end
    if (vid_acc) begin
      cmap_q_r <= cmap_ram[pack_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_req.opcode == OP_CLOUD) && !in_req.address[0]) begin
      cloud_even[in_req.address[7:1]] <= in_req.value[3:0];
    end
    if (vid_acc) begin
      ceven_q_r <= cloud_even[cloud_row];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_req.opcode == OP_CLOUD) && in_req.address[0]) begin
      cloud_odd[in_req.address[7:1]] <= in_req.value[3:0];
    end
    if (vid_acc) begin
      codd_q_r <= cloud_odd[cloud_row];
    end
  end

  // ---------------------------------------------------------------------
  // Control: flip, colour RAM sweep, frame tick divider
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r       <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      drift_row_r  <= '0;
      tick_div_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        flip_r <= cfg_wr_data;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 10'd1;
        if (clr_addr_r == '1) begin
          clr_active_r <= 1'b0;
        end
      end
      // Cloud moves one row every eighth tick
      if (in_acc && (in_req.opcode == OP_TICK)) begin
        tick_div_r <= tick_div_r + 3'd1;
        if (tick_div_r == 3'd7) begin
          drift_row_r <= drift_row_r + 8'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Read stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (vid_acc) begin
      s1_valid_r <= 1'b1;
    end else if (ser_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vid_acc) begin
      s1_val_r     <= in_req.value;
      s1_x0_r      <= in_req.address[4:0];
      s1_y_r       <= y_in;
      s1_inrange_r <= (cy <= CLOUD_ROWS);
    end
  end

  // ---------------------------------------------------------------------
  // Serializer: pixel i uses cloud bit 3-(i mod 4) of the even nibble
  // for the left four pixels and of the odd nibble for the right four.
  // ---------------------------------------------------------------------
  assign cloud_en   = s1_inrange_r && !cmap_q_r[3];
  assign cloud_bits = {codd_q_r[0], codd_q_r[1], codd_q_r[2], codd_q_r[3],
                       ceven_q_r[0], ceven_q_r[1], ceven_q_r[2], ceven_q_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= '0;
    end else begin
      if (ser_load) begin
        ser_valid_r <= 1'b1;
        ser_cnt_r   <= '0;
      end else if (ser_done) begin
        ser_valid_r <= 1'b0;
        ser_cnt_r   <= '0;
      end else if (pix_fire) begin
        ser_cnt_r <= ser_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_val_r   <= s1_val_r;
      ser_x0_r    <= s1_x0_r;
      ser_y_r     <= s1_y_r;
      ser_fore_r  <= ~cstore_q_r;
      ser_back_r  <= cmap_q_r[0] ? PEN_BACK_HI : PEN_BACK_LO;
      ser_cloud_r <= cloud_en ? cloud_bits : 8'h00;
    end
  end

  assign pix_x = {ser_x0_r, ser_cnt_r};

  always_comb begin
    if (ser_val_r[ser_cnt_r]) begin
      pix_color = ser_fore_r;
    end else if (ser_cloud_r[ser_cnt_r]) begin
      pix_color = PEN_CLOUD;
    end else begin
      pix_color = ser_back_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register; flip is 255 - v, i.e. bitwise inversion
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= ser_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      out_pix_r.pixel_x     <= flip_r ? ~pix_x : pix_x;
      out_pix_r.pixel_y     <= flip_r ? ~ser_y_r : ser_y_r;
      out_pix_r.pixel_color <= pix_color;
      out_pix_r.last        <= (ser_cnt_r == 3'd7);
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BPGCO_ASSERT_IMP(a_no_accept_in_clear, clr_active_r, in_stall, "request during sweep")
  `BPGCO_ASSERT_NXT(a_clear_ends, clr_active_r && clr_addr_r == '1, !clr_active_r, "sweep stuck")
  `BPGCO_ASSERT_NXT(a_ser_keeps_byte, pix_fire && ser_cnt_r != 3'd7, ser_valid_r, "byte cut")
  `BPGCO_ASSERT_NXT(a_s1_holds, s1_hold, s1_valid_r && $stable(s1_val_r), "s1 lost byte")

endmodule

`default_nettype wire

>>> tb/tb_bitmap_pixel_gen_cloud_overlay.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_pixel_gen_cloud_overlay: directed and random requests,
// checked pixel by pixel against an in-bench model of the colour and cloud logic.
// Depends on bpgco_pkg and the design under design/.

module tb_bitmap_pixel_gen_cloud_overlay;
  import bpgco_pkg::*;

  // Opcodes past the frame tick are decoded as no-ops by the block
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam int WATCHDOG_LIMIT   = 5000; // covers the colour RAM sweep
  localparam int DRAIN_CYCLES     = 24;   // read stage plus one full byte of pixels
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int IDLE_PERCENT     = 7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_pix_t out_pix;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;

  bitmap_pixel_gen_cloud_overlay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pix    (out_pix),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the pixel generator. Updated when a request is accepted,
  // so the next request is always built against what the block will see.
  // ---------------------------------------------------------------------------
  logic [2:0] pen_ram   [1024];
  logic [3:0] cmap_mem  [1024];
  logic [3:0] cloud_mem [256];
  bit         cmap_set  [1024];  // map and cloud entries power up undefined:
  bit         cloud_set [256];   // never let a video write read an unset one
  logic [7:0] drift_row;
  logic [2:0] tick_div;
  logic       flip_now;

  out_pix_t   pix_expected[$];
  out_pix_t   pix_want;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         idle_on = 1'b1;    // random gaps on both channels
  bit         long_hold = 1'b0;  // raised by a test, dropped by the receiver

  // Work out the effect of one accepted request; video writes queue 8 pixels.
  function automatic void predict_pixels(in_req_t r);
    logic [7:0] y, x0, x, cy;
    logic [3:0] map;
    logic [2:0] back, fore, col;
    logic       in_cloud;
    out_pix_t   p;
    case (r.opcode)
      OP_VIDEO: begin
        y        = r.address[12:5];
        x0       = {r.address[4:0], 3'b000};
        map      = cmap_mem[{y[7:3], r.address[4:0]}];
        back     = map[0] ? PEN_BACK_HI : PEN_BACK_LO;
        fore     = ~pen_ram[{r.address[12:8], r.address[4:0]}];
        cy       = y - drift_row;
        in_cloud = !map[3] && (cy <= CLOUD_ROWS);
        for (int i = 0; i < 8; i++) begin
          x = x0 + 8'(i);
          if (r.value[i])
            col = fore;
          else if (in_cloud)
            col = cloud_mem[{~cy[5:0], x[3:2]}][~x[1:0]] ? PEN_CLOUD : back;
          else
            col = back;
          p.pixel_x     = flip_now ? 8'd255 - x : x;
          p.pixel_y     = flip_now ? 8'd255 - y : y;
          p.pixel_color = col;
          p.last        = (i == 7);
          pix_expected.push_back(p);
        end
      end
      OP_COLOR: pen_ram[{r.address[12:8], r.address[4:0]}] = r.value[2:0];
      OP_CMAP: begin
        cmap_mem[r.address[9:0]] = r.value[3:0];
        cmap_set[r.address[9:0]] = 1'b1;
      end
      OP_CLOUD: begin
        cloud_mem[r.address[7:0]] = r.value[3:0];
        cloud_set[r.address[7:0]] = 1'b1;
      end
      OP_TICK: begin
        if (tick_div == 3'd7) begin
          tick_div  = 3'd0;
          drift_row = drift_row + 8'd1;
        end else begin
          tick_div = tick_div + 3'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Entered on a rising-edge step; returns on the step at which
  // the request was taken. Valid stays up so back-to-back requests need only
  // one assignment per step. Now and then one idle cycle goes in first.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] op, input logic [12:0] addr,
                          input logic [7:0] val);
    in_req_t r;
    r.opcode  = op;
    r.address = addr;
    r.value   = val;
    if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_pixels(r);
  endtask

  // Video write, preceded by loads of any map or cloud entry it would read
  // that has not been written yet (random content).
  task automatic send_video(input logic [12:0] addr, input logic [7:0] val);
    logic [9:0] mi;
    logic [7:0] y, cy, ci;
    logic [3:0] map;
    y  = addr[12:5];
    mi = {y[7:3], addr[4:0]};
    if (!cmap_set[mi])
      send_req(OP_CMAP, {3'($urandom), mi}, 8'($urandom));
    map = cmap_mem[mi];
    cy  = y - drift_row;
    if (!map[3] && cy <= CLOUD_ROWS) begin
      // one byte covers two nibbles of the cloud row: x[3:2] = {addr[0], half}
      for (int h = 0; h < 2; h++) begin
        ci = {~cy[5:0], addr[0], 1'(h)};
        if (!cloud_set[ci])
          send_req(OP_CLOUD, {5'($urandom), ci}, 8'($urandom));
      end
    end
    send_req(OP_VIDEO, addr, val);
  endtask

  // Drop valid, let every pixel come back, then let the pipe empty out
  // (table loads and ticks leave nothing in the queue to wait on).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_flip(input logic v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    flip_now  = v;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner addresses and bytes: foreground pens 0 and 7, both background pens,
  // map bit 3 set at the bottom-right corner.
  task automatic test_extremes();
    send_req(OP_COLOR, 13'h0000, 8'hFF);
    send_req(OP_COLOR, 13'h1FFF, 8'h00);
    send_req(OP_CMAP, 13'h0000, 8'h00);
    send_req(OP_CMAP, 13'h1FFF, 8'hF9);
    send_video(13'h0000, 8'hFF);
    send_video(13'h0000, 8'h00);
    send_video(13'h0000, 8'hA5);
    send_video(13'h1FFF, 8'h00);
    send_video(13'h1FFF, 8'hFF);
  endtask

  // Rows at the top edge of the cloud band, its last row, the row past it,
  // the row above it, and a band row whose map entry blocks the cloud.
  task automatic test_cloud_band();
    logic [7:0] rows [4];
    logic [4:0] col;
    logic [9:0] mi;
    rows = '{drift_row, drift_row + 8'd64, drift_row + 8'd65, drift_row - 8'd1};
    foreach (rows[k]) begin
      col = 5'($urandom);
      mi  = {rows[k][7:3], col};
      send_req(OP_CMAP, {3'($urandom), mi}, {4'($urandom), 3'b000, 1'(k)});
      send_video({rows[k], col}, 8'h00);
    end
    col = 5'($urandom);
    mi  = {drift_row[7:3], col};
    send_req(OP_CMAP, {3'b000, mi}, 8'h08);
    send_video({drift_row, col}, 8'h00);
  endtask

  // Nine ticks carry the divider past its wrap and move the cloud by one row.
  task automatic test_frame_tick();
    repeat (9) send_req(OP_TICK, 13'($urandom), 8'($urandom));
    send_video({drift_row, 5'($urandom)}, 8'h00);
  endtask

  task automatic test_unused_opcodes();
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_req(3'(op), 13'($urandom), 8'($urandom));
    send_video(13'($urandom), 8'($urandom));
  endtask

  // Receiver holds off while video writes keep coming: the read stage and
  // serializer fill and in_stall must rise.
  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (12) send_video(13'($urandom), 8'($urandom));
  endtask

  // Mostly video writes, a good share aimed at the cloud band, mixed with
  // loads, ticks (sometimes a full divider period) and unused opcodes.
  task automatic test_random(input int n);
    int          done;
    int          pick;
    logic [12:0] a;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        a = 13'($urandom);
        if ($urandom_range(99) < 40)
          a[12:5] = drift_row + 8'($urandom_range(70));
        send_video(a, ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom));
      end else if (pick < 67) begin
        send_req(OP_COLOR, 13'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        send_req(OP_CMAP, 13'($urandom), 8'($urandom));
      end else if (pick < 83) begin
        send_req(OP_CLOUD, 13'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        send_req(OP_TICK, 13'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        repeat (8) send_req(OP_TICK, 13'($urandom), 8'($urandom));
        done += 7;
      end else begin
        send_req(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                 13'($urandom), 8'($urandom));
        done--;  // ignored by the block, does not count
      end
      done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random single-cycle stalls, or one long hold-off when a test asks.
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
        out_stall <= 1'b1;
        @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Pixel checker: every accepted pixel against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pix_expected.size() == 0) begin
        $error("pixel with none pending: x=%0d y=%0d color=%0d last=%0d",
               out_pix.pixel_x, out_pix.pixel_y, out_pix.pixel_color, out_pix.last);
        mismatches++;
      end else begin
        pix_want = pix_expected.pop_front();
        if (out_pix.pixel_x !== pix_want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", pix_want.pixel_x, out_pix.pixel_x);
          mismatches++;
        end
        if (out_pix.pixel_y !== pix_want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", pix_want.pixel_y, out_pix.pixel_y);
          mismatches++;
        end
        if (out_pix.pixel_color !== pix_want.pixel_color) begin
          $error("pixel_color: expected %0d, got %0d",
                 pix_want.pixel_color, out_pix.pixel_color);
          mismatches++;
        end
        if (out_pix.last !== pix_want.last) begin
          $error("last: expected %0d, got %0d", pix_want.last, out_pix.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without a request or a pixel taken means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** bitmap_pixel_gen_cloud_overlay: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (pen_ram[k]) pen_ram[k] = 3'd0;
    foreach (cmap_mem[k]) begin
      cmap_mem[k] = 4'd0;
      cmap_set[k] = 1'b0;
    end
    foreach (cloud_mem[k]) begin
      cloud_mem[k] = 4'd0;
      cloud_set[k] = 1'b0;
    end
    drift_row = 8'd0;
    tick_div  = 3'd0;
    flip_now  = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the block's colour RAM sweep holds in_stall high for a while; the
    // first request simply waits it out
    set_flip(1'b0);
    test_extremes();
    test_cloud_band();
    test_frame_tick();
    test_unused_opcodes();

    set_flip(1'b1);
    test_cloud_band();
    test_backpressure();
    test_random(42);

    // stretch with no gaps on either side
    set_flip(1'b0);
    idle_on = 1'b0;
    test_random(42);
    wait_idle();
    idle_on = 1'b1;

    set_flip(1'b1);
    test_random(42);
    wait_idle();

    if (mismatches == 0 && pix_expected.size() == 0)
      $display("** bitmap_pixel_gen_cloud_overlay: PASSED **");
    else
      $display("** bitmap_pixel_gen_cloud_overlay: FAILED **");
    $finish;
  end

endmodule
